[hdl/order_preserving_key_encoder_macros.svh]
// Assertion macros used by the drain module.
// The macros expect signals named clk and arst_n in the calling scope.
`ifndef ORDER_PRESERVING_KEY_ENCODER_MACROS_SVH
`define ORDER_PRESERVING_KEY_ENCODER_MACROS_SVH

`ifndef SYNTH

`define OPKE_ASSERT_HOLDS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("opke: invariant violated");

`define OPKE_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("opke: implication violated");

`define OPKE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("opke: next-cycle implication violated");

`else

`define OPKE_ASSERT_HOLDS(label, expr)
`define OPKE_ASSERT_IMPLY(label, ante, cons)
`define OPKE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/opke_pkg.sv]
package opke_pkg;

	localparam int GROUP_BYTES = 8;
	localparam int MAX_BYTES   = GROUP_BYTES + 1;
	localparam int CNT_W       = $clog2(MAX_BYTES + 1);
	localparam int FILL_W      = $clog2(GROUP_BYTES);

	typedef logic [7:0]               byte_t;
	typedef logic [8*MAX_BYTES-1:0]   word_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [FILL_W-1:0]        fill_t;

	typedef enum logic [3:0] {
		KIND_U8    = 4'd0,
		KIND_U16   = 4'd1,
		KIND_U32   = 4'd2,
		KIND_U64   = 4'd3,
		KIND_I8    = 4'd4,
		KIND_I16   = 4'd5,
		KIND_I32   = 4'd6,
		KIND_I64   = 4'd7,
		KIND_F32   = 4'd8,
		KIND_F64   = 4'd9,
		KIND_STR   = 4'd10,
		KIND_EMPTY = 4'd11
	} kind_t;

	localparam byte_t MARK_CONT = 8'hFF;

	// Bytes of one item, first byte in the top lane, plus how many are valid.
	typedef struct packed {
		word_t bytes;
		cnt_t  cnt;
	} fmt_t;

endpackage

[hdl/opke_format.sv]
module opke_format (
	input  logic [3:0]      kind,
	input  logic [63:0]     value,
	input  logic            descending,
	input  logic            last_byte,
	input  opke_pkg::fill_t fill,
	output opke_pkg::fmt_t  fmt,
	output opke_pkg::fill_t fill_next
);
	import opke_pkg::*;

	logic [63:0] scal;
	logic [5:0]  sh;
	logic        is_scalar;
	cnt_t        filled;
	cnt_t        cnt;
	word_t       raw;

	assign filled = cnt_t'(fill) + cnt_t'(1);

	always_comb begin
		scal      = '0;
		sh        = '0;
		is_scalar = 1'b0;
		cnt       = '0;
		raw       = '0;
		fill_next = '0;
		unique case (kind_t'(kind))
			KIND_U8: begin
				scal = {56'b0, value[7:0]};
				sh = 6'd56; cnt = cnt_t'(1); is_scalar = 1'b1;
			end
			KIND_U16: begin
				scal = {48'b0, value[15:0]};
				sh = 6'd48; cnt = cnt_t'(2); is_scalar = 1'b1;
			end
			KIND_U32: begin
				scal = {32'b0, value[31:0]};
				sh = 6'd32; cnt = cnt_t'(4); is_scalar = 1'b1;
			end
			KIND_U64: begin
				scal = value;
				sh = 6'd0; cnt = cnt_t'(8); is_scalar = 1'b1;
			end
			KIND_I8: begin
				scal = {56'b0, ~value[7], value[6:0]};
				sh = 6'd56; cnt = cnt_t'(1); is_scalar = 1'b1;
			end
			KIND_I16: begin
				scal = {48'b0, ~value[15], value[14:0]};
				sh = 6'd48; cnt = cnt_t'(2); is_scalar = 1'b1;
			end
			KIND_I32: begin
				scal = {32'b0, ~value[31], value[30:0]};
				sh = 6'd32; cnt = cnt_t'(4); is_scalar = 1'b1;
			end
			KIND_I64: begin
				scal = {~value[63], value[62:0]};
				sh = 6'd0; cnt = cnt_t'(8); is_scalar = 1'b1;
			end
			KIND_F32: begin
				scal = value[31] ? {32'b0, ~value[31:0]} : {32'b0, 1'b1, value[30:0]};
				sh = 6'd32; cnt = cnt_t'(4); is_scalar = 1'b1;
			end
			KIND_F64: begin
				scal = value[63] ? ~value : {1'b1, value[62:0]};
				sh = 6'd0; cnt = cnt_t'(8); is_scalar = 1'b1;
			end
			KIND_STR: begin
				if (!last_byte) begin
					if (filled == cnt_t'(GROUP_BYTES)) begin
						raw[8*MAX_BYTES-1 -: 8] = value[7:0];
						raw[8*MAX_BYTES-9 -: 8] = MARK_CONT;
						cnt = cnt_t'(2);
					end else begin
						raw[8*MAX_BYTES-1 -: 8] = value[7:0];
						cnt = cnt_t'(1);
						fill_next = filled[FILL_W-1:0];
					end
				end else begin
					// data byte, zero pad to a full group, then the real byte count
					cnt = cnt_t'(MAX_BYTES + 1) - filled;
					for (int i = 0; i < MAX_BYTES; i++) begin
						if (i == 0)
							raw[8*(MAX_BYTES-1-i) +: 8] = value[7:0];
						else if (cnt_t'(i + 1) == cnt)
							raw[8*(MAX_BYTES-1-i) +: 8] = byte_t'(filled);
					end
				end
			end
			KIND_EMPTY: begin
				cnt = cnt_t'(MAX_BYTES);
			end
			default: begin
				// undefined kinds emit nothing and keep the open group
				fill_next = fill;
			end
		endcase
		if (is_scalar)
			raw = word_t'({scal, 8'h00}) << sh;
	end

	assign fmt.bytes = descending ? ~raw : raw;
	assign fmt.cnt   = cnt;

endmodule

[hdl/opke_drain.sv]
`include "order_preserving_key_encoder_macros.svh"

module opke_drain (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  opke_pkg::fmt_t fmt,
	output logic           ready,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic           run_end
);
	import opke_pkg::*;

	word_t buf_q;
	cnt_t  cnt_q;
	logic  out_valid_q;
	byte_t out_byte_q;
	logic  run_end_q;
	logic  move;

	// advance one byte whenever the output register is free or being emptied
	assign move  = (cnt_q != '0) && (!out_valid_q || !out_stall);
	assign ready = (cnt_q == '0) || ((cnt_q == cnt_t'(1)) && move);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				cnt_q <= fmt.cnt;
			else if (move)
				cnt_q <= cnt_q - cnt_t'(1);
			if (move)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			buf_q <= fmt.bytes;
		else if (move)
			buf_q <= buf_q << 8;
		if (move) begin
			out_byte_q <= buf_q[8*MAX_BYTES-1 -: 8];
			run_end_q  <= (cnt_q == cnt_t'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_end   = run_end_q;

	`OPKE_ASSERT_HOLDS(a_cnt_range, cnt_q <= cnt_t'(MAX_BYTES))
	`OPKE_ASSERT_IMPLY(a_load_only_when_draining_out, load, cnt_q <= cnt_t'(1))
	`OPKE_ASSERT_NEXT(a_idle_output_fills, (cnt_q != '0) && !out_valid_q, out_valid_q)
	`OPKE_ASSERT_NEXT(a_last_byte_marks_end, move && (cnt_q == cnt_t'(1)), out_valid_q && run_end_q)

endmodule

[hdl/order_preserving_key_encoder.sv]
// Order-preserving key encoder. Each input beat carries one typed key part
// (unsigned or signed integer of 1/2/4/8 bytes, float32, float64, one string
// byte, or an empty string) and is turned into 1 to 9 output bytes, most
// significant first, whose unsigned byte order follows the order of the values;
// descending inverts every byte of that beat. Strings are cut into 8-byte groups:
// a full group that is not the last is followed by 0xFF, the final group is zero
// padded and followed by its count of real bytes. run_end marks the last output
// byte of each input beat. The input is formatted straight into a byte buffer,
// and the buffer drains one byte per cycle into the output register whenever
// out_stall does not hold a waiting byte there. A string byte that does not
// close a group emits one byte, one that does emits two, a closing byte emits
// up to nine, an empty string nine, and scalars 1/2/4/8. A new beat is taken in
// the cycle the buffer hands out its final byte, so while the output is not
// stalled single-byte beats stream at one per clock. Kinds 12 to 15 are
// accepted and emit nothing.
module order_preserving_key_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  kind,
	input  logic [63:0] value,
	input  logic        descending,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        run_end
);
	import opke_pkg::*;

	fmt_t  fmt;
	fill_t fill_next;
	fill_t group_fill_q;
	logic  ready;
	logic  load;

	// format the beat on the way into the drain buffer
	opke_format u_format (
		.kind       (kind),
		.value      (value),
		.descending (descending),
		.last_byte  (last_byte),
		.fill       (group_fill_q),
		.fmt        (fmt),
		.fill_next  (fill_next)
	);

	// hold the formatted bytes and hand them out one per cycle unless out_stall holds the output
	opke_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.fmt       (fmt),
		.ready     (ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_end   (run_end)
	);

	assign in_stall = !ready;
	assign load     = in_valid && ready;

	// count of string bytes in the open group; any non-string beat of a defined kind closes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			group_fill_q <= '0;
		else if (load)
			group_fill_q <= fill_next;
	end

endmodule
